FILE: rtl/core/srb_pkg.sv
package srb_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int REQ_W     = 7;
   localparam int OQ_DEPTH  = 4;
   localparam int OQ_IDX_W  = 2;
   localparam int OQ_CNT_W  = 3;
   localparam int CQ_DEPTH  = 2;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_PULL = 1'b1
   } op_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_PULL
   } back_state_type;

   // Decoded command handed from the front end to the back end
   typedef struct packed {
      op_type                       operation;
      logic signed [SAMPLE_W-1:0]   sample;
      logic                         batch_end;
      logic [REQ_W-1:0]             count;
   } cmd_type;

   // One result word as it waits in the output queue
   typedef struct packed {
      logic signed [SAMPLE_W-1:0]   sample;
      logic                         last;
      logic                         under;
      logic                         over;
      logic                         pad;
   } word_type;

endpackage

FILE: rtl/core/srb_if.sv
interface srb_req_if import srb_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic signed [SAMPLE_W-1:0]   sample_in;
   logic                         batch_end;
   logic [REQ_W-1:0]             request_count;

   modport source (output valid, operation, sample_in, batch_end, request_count,
                   input ready);
   modport sink (input valid, operation, sample_in, batch_end, request_count,
                 output ready);
endinterface

interface srb_rsp_if import srb_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [SAMPLE_W-1:0]   sample_out;
   logic                         last_of_run;
   logic                         underrun;
   logic                         overrun;
   logic                         padded;

   modport source (output valid, sample_out, last_of_run, underrun, overrun, padded,
                   input ready);
   modport sink (input valid, sample_out, last_of_run, underrun, overrun, padded,
                 output ready);
endinterface

FILE: rtl/core/srb_front.sv
module srb_front import srb_pkg::*; #(
   parameter int MAX_REQUEST = 64
) (
   input  logic        clock,
   input  logic        reset,
   srb_req_if.sink     req_chan,
   output cmd_type     cmd,
   output logic        cmd_valid,
   input  logic        cmd_pop
);

   cmd_type          cq_ff [CQ_DEPTH];
   cmd_type          cq_in [CQ_DEPTH];
   logic             head_ff, head_in;
   logic [1:0]       cnt_ff, cnt_in;

   logic [REQ_W-1:0] count_sat;
   logic             keep;
   logic             accept;
   logic             enq;
   logic             tail;
   cmd_type          decoded;

   always_comb begin
      count_sat = (req_chan.request_count > REQ_W'(MAX_REQUEST)) ?
                  REQ_W'(MAX_REQUEST) : req_chan.request_count;
      decoded.operation = op_type'(req_chan.operation);
      decoded.sample    = req_chan.sample_in;
      decoded.batch_end = req_chan.batch_end;
      decoded.count     = count_sat;
      // drop pulls that ask for nothing
      keep   = (decoded.operation == OP_PUSH) || (count_sat != '0);
      accept = req_chan.valid && req_chan.ready;
      enq    = accept && keep;
      tail   = head_ff ^ cnt_ff[0];
   end

   assign req_chan.ready = (cnt_ff != 2'(CQ_DEPTH));
   assign cmd_valid      = (cnt_ff != '0);
   assign cmd            = cq_ff[head_ff];

   always_comb begin
      cq_in   = cq_ff;
      head_in = head_ff;
      cnt_in  = cnt_ff;
      if (enq) begin
         cq_in[tail] = decoded;
      end
      if (cmd_pop && cmd_valid) begin
         head_in = ~head_ff;
      end
      cnt_in = cnt_ff + 2'(enq) - 2'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         head_ff <= head_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cq_ff <= cq_in;
   end

endmodule

FILE: rtl/core/srb_back.sv
module srb_back import srb_pkg::*; #(
   parameter int DEPTH = 384
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  logic        cmd_valid,
   output logic        cmd_pop,
   srb_rsp_if.source   rsp_chan
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > REQ_W) ? CNT_W : REQ_W;

   logic signed [SAMPLE_W-1:0] sample_mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rdata_ff;

   back_state_type             state_ff, state_in;
   logic [PTR_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic                       over_ff, over_in;
   logic                       batch_start_ff, batch_start_in;
   logic signed [SAMPLE_W-1:0] hold_ff, hold_in;
   logic [REQ_W-1:0]           remain_ff, remain_in;
   logic [REQ_W-1:0]           copy_ff, copy_in;
   logic                       under_ff, under_in;

   logic                       s1_valid_ff, s1_valid_in;
   logic                       s1_pad_ff, s1_pad_in;
   logic                       s1_last_ff, s1_last_in;
   logic                       s1_under_ff, s1_under_in;
   logic                       s1_over_ff, s1_over_in;

   word_type                   oq_ff [OQ_DEPTH];
   word_type                   oq_in [OQ_DEPTH];
   logic [OQ_IDX_W-1:0]        oq_head_ff, oq_head_in;
   logic [OQ_CNT_W-1:0]        oq_cnt_ff, oq_cnt_in;

   logic [SUM_W-1:0]           wr_sum;
   logic [PTR_W-1:0]           wr_addr;
   logic [PTR_W-1:0]           rd_next;
   logic                       mem_wr_en;
   logic                       mem_rd_en;
   logic                       can_issue;
   logic                       pull_under;
   logic                       issue_pad;
   logic                       oq_pop;
   logic [OQ_IDX_W-1:0]        oq_tail;
   word_type                   new_word;

   always_comb begin
      wr_sum  = SUM_W'(rd_ptr_ff) + SUM_W'(fill_ff);
      wr_addr = (wr_sum >= SUM_W'(DEPTH)) ? PTR_W'(wr_sum - SUM_W'(DEPTH)) : PTR_W'(wr_sum);
      rd_next = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      // leave room in the output queue for the read still in flight
      can_issue  = (oq_cnt_ff + OQ_CNT_W'(s1_valid_ff)) < OQ_CNT_W'(OQ_DEPTH);
      pull_under = CMP_W'(cmd.count) >= CMP_W'(fill_ff);
      issue_pad  = (copy_ff == '0);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && cmd.operation == OP_PULL) begin
               state_in = BACK_PULL;
            end
         end
         BACK_PULL: begin
            if (can_issue && remain_ff == REQ_W'(1)) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // datapath and control outputs
   always_comb begin
      cmd_pop        = 1'b0;
      mem_wr_en      = 1'b0;
      mem_rd_en      = 1'b0;
      rd_ptr_in      = rd_ptr_ff;
      fill_in        = fill_ff;
      over_in        = over_ff;
      batch_start_in = batch_start_ff;
      remain_in      = remain_ff;
      copy_in        = copy_ff;
      under_in       = under_ff;
      s1_valid_in    = 1'b0;
      s1_pad_in      = s1_pad_ff;
      s1_last_in     = s1_last_ff;
      s1_under_in    = s1_under_ff;
      s1_over_in     = s1_over_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.operation == OP_PUSH) begin
                  mem_wr_en      = 1'b1;
                  batch_start_in = cmd.batch_end;
                  if (fill_ff < CNT_W'(DEPTH)) begin
                     fill_in = fill_ff + CNT_W'(1);
                     over_in = batch_start_ff ? 1'b0 : over_ff;
                  end else begin
                     // full: drop the oldest word
                     rd_ptr_in = rd_next;
                     over_in   = 1'b1;
                  end
               end else begin
                  remain_in = cmd.count;
                  under_in  = pull_under;
                  copy_in   = pull_under ? REQ_W'(fill_ff) : cmd.count;
               end
            end
         end
         BACK_PULL: begin
            if (can_issue) begin
               s1_valid_in = 1'b1;
               s1_pad_in   = issue_pad;
               s1_last_in  = (remain_ff == REQ_W'(1));
               s1_under_in = under_ff;
               s1_over_in  = over_ff;
               remain_in   = remain_ff - REQ_W'(1);
               if (!issue_pad) begin
                  mem_rd_en = 1'b1;
                  rd_ptr_in = rd_next;
                  fill_in   = fill_ff - CNT_W'(1);
                  copy_in   = copy_ff - REQ_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         sample_mem[wr_addr] <= cmd.sample;
      end
      if (mem_rd_en) begin
         rdata_ff <= sample_mem[rd_ptr_ff];
      end
   end

   // output queue fill and drain
   always_comb begin
      oq_pop           = rsp_chan.valid && rsp_chan.ready;
      oq_tail          = oq_head_ff + oq_cnt_ff[OQ_IDX_W-1:0];
      new_word.sample  = s1_pad_ff ? hold_ff : rdata_ff;
      new_word.last    = s1_last_ff;
      new_word.under   = s1_under_ff;
      new_word.over    = s1_over_ff;
      new_word.pad     = s1_pad_ff;
      hold_in          = (s1_valid_ff && !s1_pad_ff) ? rdata_ff : hold_ff;
      oq_in            = oq_ff;
      if (s1_valid_ff) begin
         oq_in[oq_tail] = new_word;
      end
      oq_head_in = oq_pop ? oq_head_ff + OQ_IDX_W'(1) : oq_head_ff;
      oq_cnt_in  = oq_cnt_ff + OQ_CNT_W'(s1_valid_ff) - OQ_CNT_W'(oq_pop);
   end

   assign rsp_chan.valid       = (oq_cnt_ff != '0);
   assign rsp_chan.sample_out  = oq_ff[oq_head_ff].sample;
   assign rsp_chan.last_of_run = oq_ff[oq_head_ff].last;
   assign rsp_chan.underrun    = oq_ff[oq_head_ff].under;
   assign rsp_chan.overrun     = oq_ff[oq_head_ff].over;
   assign rsp_chan.padded      = oq_ff[oq_head_ff].pad;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BACK_IDLE;
         rd_ptr_ff      <= '0;
         fill_ff        <= '0;
         over_ff        <= 1'b0;
         batch_start_ff <= 1'b1;
         hold_ff        <= '0;
         remain_ff      <= '0;
         copy_ff        <= '0;
         under_ff       <= 1'b0;
         s1_valid_ff    <= 1'b0;
         oq_head_ff     <= '0;
         oq_cnt_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         rd_ptr_ff      <= rd_ptr_in;
         fill_ff        <= fill_in;
         over_ff        <= over_in;
         batch_start_ff <= batch_start_in;
         hold_ff        <= hold_in;
         remain_ff      <= remain_in;
         copy_ff        <= copy_in;
         under_ff       <= under_in;
         s1_valid_ff    <= s1_valid_in;
         oq_head_ff     <= oq_head_in;
         oq_cnt_ff      <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pad_ff   <= s1_pad_in;
      s1_last_ff  <= s1_last_in;
      s1_under_ff <= s1_under_in;
      s1_over_ff  <= s1_over_in;
      oq_ff       <= oq_in;
   end

endmodule

FILE: rtl/core/sample_ring_buffer_hold_last.sv
// Ring FIFO of signed 8-bit samples. A push word stores one sample; when the ring is
// full the oldest sample is overwritten and overrun is reported for the current batch
// (batch_end closes a batch). A pull word asks for request_count samples (saturated to
// MAX_REQUEST, zero asks for nothing) and gets exactly that many result words; when the
// request reaches the fill level, the ring is drained and the run is padded with the
// last delivered sample, with underrun set on every word of the run. Input words go
// into a two-entry command queue, so req_chan takes a word per cycle until that queue
// is full. The back end takes a push in its idle state and, for a pull, loads the count
// and then issues one word per cycle while rsp_chan is ready; the single-port sample
// memory has a registered read, covered by a four-entry output queue. The memory needs
// no clearing after reset.
module sample_ring_buffer_hold_last import srb_pkg::*; #(
   parameter int DEPTH       = 384,
   parameter int MAX_REQUEST = 64
) (
   input  logic        clock,
   input  logic        reset,
   srb_req_if.sink     req_chan,
   srb_rsp_if.source   rsp_chan
);

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   srb_front #(
      .MAX_REQUEST(MAX_REQUEST)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   srb_back #(
      .DEPTH(DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: rtl/core/srb_checker.sv
module srb_checker import srb_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input logic                       rsp_last_of_run,
   input logic                       rsp_underrun,
   input logic                       rsp_overrun,
   input logic                       rsp_padded
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
         && $stable(rsp_last_of_run) && $stable(rsp_padded))
      else $error("rsp word changed while stalled");

   // padding only happens on an underrun run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_padded |-> rsp_underrun)
      else $error("padded word without underrun");

   // once padding starts, the rest of the run is padding
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_padded && !rsp_last_of_run
         |=> !rsp_valid || (rsp_padded && rsp_underrun && $stable(rsp_overrun)))
      else $error("stored word after padding in one run");

   // reset empties the output side
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind sample_ring_buffer_hold_last srb_checker u_srb_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_sample_out  (rsp_chan.sample_out),
   .rsp_last_of_run (rsp_chan.last_of_run),
   .rsp_underrun    (rsp_chan.underrun),
   .rsp_overrun     (rsp_chan.overrun),
   .rsp_padded      (rsp_chan.padded)
);

FILE: test/srb_run_checker.sv
module srb_run_checker import srb_pkg::*; #(
   parameter int DEPTH       = 384,
   parameter int MAX_REQUEST = 64
) (
   input  logic clock,
   input  logic reset,
   srb_req_if   req,
   srb_rsp_if   rsp,
   output int   fails,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [SAMPLE_W-1:0]   ring_mem [DEPTH];
   int unsigned                  oldest_idx;
   int unsigned                  fill_count;
   logic signed [SAMPLE_W-1:0]   hold_value;
   logic                         over_flag;
   logic                         batch_open;
   word_type                     due_words [$];

   task automatic report(string field, logic signed [SAMPLE_W-1:0] want,
                         logic signed [SAMPLE_W-1:0] got);
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   task automatic check_word(word_type got);
      word_type want;
      if (due_words.size() == 0) begin
         fails++;
         $display("%0t: unexpected word, expected none, actual sample_out %0d",
                  $time, got.sample);
         return;
      end
      want = due_words.pop_front();
      if (got.sample !== want.sample) report("sample_out", want.sample, got.sample);
      if (got.last !== want.last) report("last_of_run", want.last, got.last);
      if (got.under !== want.under) report("underrun", want.under, got.under);
      if (got.over !== want.over) report("overrun", want.over, got.over);
      if (got.pad !== want.pad) report("padded", want.pad, got.pad);
   endtask

   task automatic model_command(cmd_type c);
      int unsigned n;
      int unsigned copy;
      logic        under;
      word_type    w;
      if (c.operation == OP_PUSH) begin
         if (batch_open) over_flag = 1'b0;
         ring_mem[(oldest_idx + fill_count) % DEPTH] = c.sample;
         if (fill_count < DEPTH) begin
            fill_count++;
         end else begin
            // full ring: overwrite the oldest sample
            oldest_idx = (oldest_idx + 1) % DEPTH;
            over_flag = 1'b1;
         end
         batch_open = c.batch_end;
      end else begin
         // saturate the count; a zero count yields no words
         n = (c.count > MAX_REQUEST) ? MAX_REQUEST : c.count;
         under = (n >= fill_count);
         copy = under ? fill_count : n;
         for (int unsigned k = 0; k < n; k++) begin
            if (k < copy) begin
               hold_value = ring_mem[oldest_idx];
               oldest_idx = (oldest_idx + 1) % DEPTH;
               fill_count--;
            end
            w.sample = hold_value;
            w.last   = (k + 1 == n);
            w.under  = under;
            w.over   = over_flag;
            w.pad    = (k >= copy);
            due_words.push_back(w);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         oldest_idx = 0;
         fill_count = 0;
         hold_value = '0;
         over_flag  = 1'b0;
         batch_open = 1'b1;
         due_words.delete();
      end else begin
         // words leaving this edge come from earlier commands
         if (rsp.valid && rsp.ready)
            check_word('{rsp.sample_out, rsp.last_of_run, rsp.underrun, rsp.overrun,
                         rsp.padded});
         if (req.valid && req.ready)
            model_command('{op_type'(req.operation), req.sample_in, req.batch_end,
                            req.request_count});
      end
      pending = due_words.size();
   end

endmodule

FILE: test/tb.sv
module tb import srb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = 384;
   localparam int MAX_REQUEST  = 64;
   localparam int LONG_HOLD    = 300;
   localparam int TAIL_CYCLES  = 2 * MAX_REQUEST + 16;
   localparam int TARGET_WORDS = 200;

   logic clock     = 1'b0;
   logic reset     = 1'b1;
   logic stall_ask = 1'b0;
   int   fails;
   int   pending;
   int   level     = 0;
   int   calm_left = 0;

   srb_req_if req_chan ();
   srb_rsp_if rsp_chan ();

   sample_ring_buffer_hold_last #(
      .DEPTH       (DEPTH),
      .MAX_REQUEST (MAX_REQUEST)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   srb_run_checker #(
      .DEPTH       (DEPTH),
      .MAX_REQUEST (MAX_REQUEST)
   ) u_checker (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .rsp     (rsp_chan),
      .fails   (fails),
      .pending (pending)
   );

   always #1 clock = ~clock;

   task automatic send_word(op_type op, logic signed [SAMPLE_W-1:0] smp, logic bend,
                            logic [REQ_W-1:0] cnt);
      int gap;
      int roll;
      gap = 0;
      if (calm_left > 0) begin
         calm_left--;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 4) calm_left = $urandom_range(10, 40);
         else if (roll < 60) gap = 0;
         else if (roll < 90) gap = $urandom_range(1, 3);
         else gap = $urandom_range(5, 25);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.operation     <= op;
      req_chan.sample_in     <= smp;
      req_chan.batch_end     <= bend;
      req_chan.request_count <= cnt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic push_sample(logic signed [SAMPLE_W-1:0] smp, logic bend);
      send_word(OP_PUSH, smp, bend, REQ_W'($urandom));
      if (level < DEPTH) level++;
   endtask

   task automatic pull_run(int cnt);
      int n;
      n = (cnt > MAX_REQUEST) ? MAX_REQUEST : cnt;
      send_word(OP_PULL, SAMPLE_W'($urandom), 1'($urandom), REQ_W'(cnt));
      level -= (n < level) ? n : level;
   endtask

   // hold the sender until every expected word has come back
   task automatic settle();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0:       return 8'h7F;
         1:       return 8'h80;
         2:       return 8'h00;
         3:       return 8'hFF;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic int pick_count();
      int cnt;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (level > 1) cnt = $urandom_range(1, (level - 1 > 63) ? 63 : level - 1);
            else cnt = $urandom_range(1, 4);
         end
         4, 5:    cnt = level + $urandom_range(0, 2);
         6, 7:    cnt = $urandom_range(1, MAX_REQUEST);
         default: cnt = $urandom_range(MAX_REQUEST + 1, 127);
      endcase
      if (cnt < 1) cnt = 1;
      if (cnt > 127) cnt = 127;
      return cnt;
   endfunction

   // receiver: random ready runs, plus one long hold-off on request
   initial begin
      int   run_left;
      logic run_ready;
      int   roll;
      run_left = 0;
      run_ready = 1'b1;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_ask) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            stall_ask = 1'b0;
         end
         if (run_left == 0) begin
            roll = $urandom_range(0, 9);
            if (roll < 3) begin
               run_ready = 1'b1;
               run_left = $urandom_range(20, 80);
            end else if (roll < 9) begin
               run_ready = ~run_ready;
               run_left = $urandom_range(1, 3);
            end else begin
               run_ready = 1'b0;
               run_left = $urandom_range(8, 40);
            end
         end
         rsp_chan.ready <= run_ready;
         run_left--;
      end
   end

   initial begin
      int counted;
      int batch_len;
      int roll;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_PUSH;
      req_chan.sample_in = '0;
      req_chan.batch_end = 1'b0;
      req_chan.request_count = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty ring after reset, zero request, extreme samples
      pull_run(1);
      pull_run(0);
      push_sample(8'h7F, 1'b0);
      push_sample(8'h80, 1'b0);
      push_sample(8'h00, 1'b1);
      push_sample(8'hFF, 1'b1);
      pull_run(1);
      pull_run(3);
      // pull inside an open batch, oversized request
      push_sample(8'h55, 1'b0);
      push_sample(8'hAA, 1'b0);
      pull_run(127);
      push_sample(8'h01, 1'b1);
      pull_run(MAX_REQUEST);
      pull_run(2);
      settle();

      // wrap the ring to force overwrites, then drain it completely
      repeat (DEPTH + 6) push_sample(pick_sample(), 1'b0);
      pull_run(5);
      push_sample(pick_sample(), 1'b1);
      push_sample(pick_sample(), 1'b0);
      pull_run(3);
      repeat (8) push_sample(pick_sample(), 1'b0);
      push_sample(pick_sample(), 1'b1);
      repeat (7) pull_run(MAX_REQUEST);
      settle();

      // back up the block behind a stalled receiver
      repeat (20) push_sample(pick_sample(), $urandom_range(0, 4) == 0);
      stall_ask = 1'b1;
      repeat (12) pull_run($urandom_range(3, 9));
      settle();

      counted = 0;
      while (counted < TARGET_WORDS) begin
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            batch_len = $urandom_range(1, 10);
            for (int i = 0; i < batch_len; i++)
               push_sample(pick_sample(), (i == batch_len - 1) ?
                           ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0));
            counted += batch_len;
         end else if (roll < 92) begin
            pull_run(pick_count());
            counted++;
         end else begin
            pull_run(0);
         end
         if ($urandom_range(0, 29) == 0) settle();
      end
      settle();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (fails == 0 && pending == 0) begin
         $display("sample_ring_buffer_hold_last regression: pass");
      end else begin
         $display("sample_ring_buffer_hold_last regression: fail");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d words outstanding", $time, pending);
      $display("sample_ring_buffer_hold_last regression: fail");
      $finish;
   end

endmodule

FILE: sim.f
rtl/core/srb_pkg.sv
rtl/core/srb_if.sv
rtl/core/srb_front.sv
rtl/core/srb_back.sv
rtl/core/sample_ring_buffer_hold_last.sv
rtl/core/srb_checker.sv
test/srb_run_checker.sv
test/tb.sv
